// ----- rtl/spl_pkg.sv -----
package spl_pkg;

	// Default depth of the sorted store.
	localparam int CAPACITY_DEF = 16;

	// Field widths of one stored entry.
	localparam int ID_W   = 16;
	localparam int KEY_W  = 16;
	localparam int PRI_W  = 8;
	localparam int ARR_W  = 32;
	localparam int RT_W   = 16;

	// Request payload: id, key, priority, arrival, run time (88 bits, whole bytes).
	localparam int IN_BITS = ID_W + KEY_W + PRI_W + ARR_W + RT_W;
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

	// Result bits ahead of the occupancy field: ok, full_reject, head_valid and the head entry.
	localparam int RES_FIXED_BITS = 3 + IN_BITS;

	// Request kind carried in tuser.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// One stored entry; the last field (id) sits in the lowest bits when packed.
	typedef struct packed {
		logic [RT_W-1:0]  run_time;
		logic [ARR_W-1:0] arrival;
		logic [PRI_W-1:0] priority_v;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic   ins_en;
		logic   del_en;
		entry_t data;
	} cmd_t;

	// What a cell shows to its neighbours.
	typedef struct packed {
		entry_t entry;
		logic   used;
		logic   le;
		logic   found;
	} cell_view_t;

	// Status of the row as a whole.
	typedef struct packed {
		logic full;
		logic found;
	} chain_stat_t;

endpackage

// ----- rtl/spl_cell.sv -----
module spl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spl_pkg::cmd_t      cmd,
	input  spl_pkg::cell_view_t left_view,
	input  spl_pkg::cell_view_t right_view,
	output spl_pkg::cell_view_t view
);
	import spl_pkg::*;

	entry_t entry_q;
	logic   used_q;
	entry_t entry_d;
	logic   used_d;
	logic   match;

	// Local compares against the broadcast request.
	assign match = used_q && (entry_q.id == cmd.data.id);

	always_comb begin
		view.entry = entry_q;
		view.used  = used_q;
		view.le    = used_q && (entry_q.key <= cmd.data.key);
		view.found = left_view.found | match;
	end

	// Next contents: keep, take the new entry, shift right on insert or shift left on delete.
	always_comb begin
		entry_d = entry_q;
		used_d  = used_q;
		if (cmd.ins_en) begin
			if (view.le) begin
				entry_d = entry_q;
				used_d  = used_q;
			end else if (left_view.le) begin
				entry_d = cmd.data;
				used_d  = 1'b1;
			end else begin
				entry_d = left_view.entry;
				used_d  = left_view.used;
			end
		end else if (cmd.del_en && view.found) begin
			entry_d = right_view.entry;
			used_d  = right_view.used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else begin
			used_q <= used_d;
		end
	end

	// Payload holds no reset; it is only read while the used bit is set.
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ----- rtl/spl_chain.sv -----
module spl_chain #(
	parameter int CAPACITY = spl_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spl_pkg::cmd_t        cmd,
	output spl_pkg::entry_t      head_entry,
	output logic                 head_used,
	output spl_pkg::chain_stat_t stat
);
	import spl_pkg::*;

	cell_view_t views [CAPACITY];
	cell_view_t edge_left;
	cell_view_t edge_right;

	// The head sees a virtual neighbour that sorts before everything; the tail sees an empty one.
	always_comb begin
		edge_left       = '0;
		edge_left.used  = 1'b1;
		edge_left.le    = 1'b1;
		edge_left.found = 1'b0;
		edge_right      = '0;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_view_t lv;
		cell_view_t rv;
		if (i == 0) begin : g_first
			assign lv = edge_left;
		end else begin : g_mid_l
			assign lv = views[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = edge_right;
		end else begin : g_mid_r
			assign rv = views[i+1];
		end
		spl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_view  (lv),
			.right_view (rv),
			.view       (views[i])
		);
	end

	assign head_entry = views[0].entry;
	assign head_used  = views[0].used;
	assign stat.full  = views[CAPACITY-1].used;
	assign stat.found = views[CAPACITY-1].found;

endmodule

// ----- rtl/stable_priority_list.sv -----
// Stable sorted store of up to CAPACITY process entries, kept in ascending key order with equal
// keys in arrival order. Each request on the slave stream (tuser 0 = insert, 1 = delete by id)
// produces exactly one result on the master stream showing whether it succeeded, whether an
// insert was refused because the store was full, the head entry and the occupancy. A request is
// taken by the whole row together: every cell compares its key and id with the request at once and
// moves its entry to a neighbour in the same clock, so one request per cycle is sustained while
// results are taken; the result is registered and shows in the cycle after its request. The
// only long path is the one-bit first-match chain that runs along the row on a delete. No
// clearing pass is needed after reset.
module stable_priority_list #(
	parameter int CAPACITY = spl_pkg::CAPACITY_DEF,
	localparam int CW      = $clog2(CAPACITY + 1),
	localparam int OUT_W   = ((spl_pkg::RES_FIXED_BITS + CW + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// proc_id, sort_key, proc_priority, arrival, run_time
	input  logic [spl_pkg::IN_W-1:0] s_tdata,
	// op
	input  logic                    s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// ok, full_reject, head_valid, head_id, head_key, head_priority, head_arrival,
	// head_run_time, occupancy, zero padding
	output logic [OUT_W-1:0]        m_tdata
);
	import spl_pkg::*;

	logic          accept;
	op_t           op;
	cmd_t          cmd;
	entry_t        head_entry;
	entry_t        head_shown;
	logic          head_used;
	chain_stat_t   stat;
	logic          ok_d;
	logic          m_tvalid_q;
	logic          ok_q;
	logic          full_q;
	logic [CW-1:0] count_q;

	// A new request is taken whenever the result register is free or being emptied.
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);

	always_comb begin
		cmd.data   = entry_t'(s_tdata[IN_BITS-1:0]);
		cmd.ins_en = accept && (op == OP_INSERT) && !stat.full;
		cmd.del_en = accept && (op == OP_DELETE);
		ok_d       = (op == OP_INSERT) ? !stat.full : stat.found;
	end

	spl_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.head_entry (head_entry),
		.head_used  (head_used),
		.stat       (stat)
	);

	// Result flags and occupancy; the head is read live from the first cell, which only
	// changes when the next transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			ok_q       <= 1'b0;
			full_q     <= 1'b0;
			count_q    <= '0;
		end else begin
			if (accept) begin
				m_tvalid_q <= 1'b1;
				ok_q       <= ok_d;
				full_q     <= (op == OP_INSERT) && stat.full;
				if (cmd.ins_en) begin
					count_q <= count_q + CW'(1);
				end else if (cmd.del_en && stat.found) begin
					count_q <= count_q - CW'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign head_shown = head_used ? head_entry : '0;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = OUT_W'({count_q, head_shown, head_used, full_q, ok_q});

endmodule

// ----- rtl/spl_checker.sv -----
module spl_checker #(
	parameter int CAPACITY = spl_pkg::CAPACITY_DEF,
	localparam int CW      = $clog2(CAPACITY + 1),
	localparam int OUT_W   = ((spl_pkg::RES_FIXED_BITS + CW + 7) / 8) * 8
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_W-1:0]         m_tdata
);
	import spl_pkg::*;

	localparam int OCC_LO = RES_FIXED_BITS;

	logic          res_ok;
	logic          res_full;
	logic          res_head_valid;
	logic [CW-1:0] res_occ;

	assign res_ok         = m_tdata[0];
	assign res_full       = m_tdata[1];
	assign res_head_valid = m_tdata[2];
	assign res_occ        = m_tdata[OCC_LO +: CW];

	// Every accepted request gives a result in the next cycle; an insert either succeeds or is
	// refused for fullness, a delete never reports fullness.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid &&
			(($past(s_tuser) == OP_DELETE) ? !res_full : (res_ok != res_full)))
		else $error("result flags do not match the request kind");

	// The head is shown exactly when the store is not empty.
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_head_valid == (res_occ != '0)))
		else $error("head_valid disagrees with occupancy");

	// Occupancy never exceeds the capacity, and a refusal only happens when it is reached.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_occ <= CW'(CAPACITY)) && (!res_full || (res_occ == CW'(CAPACITY))))
		else $error("occupancy out of range or refusal while not full");

	// A successful insert raises the count by one over the previous result.
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && s_tvalid && s_tready && (s_tuser == OP_INSERT) &&
			(res_occ != CW'(CAPACITY)))
		|=> (res_occ == $past(res_occ) + CW'(1)))
		else $error("insert did not raise occupancy by one");

endmodule

bind stable_priority_list spl_checker #(
	.CAPACITY (CAPACITY)
) u_spl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
